@@ sv/epoch_seconds_to_calendar_date_unit_defines.svh @@
// assertion macros for the epoch seconds to calendar date unit
// used by the top level only; expects clk and rst_n in scope
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ESCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ESCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/escd_pkg.sv @@
// shared constants, types and the month length table of the date unit
// no dependencies
`timescale 1ns / 1ps

package escd_pkg;

    // input width and derived widths
    localparam int SECONDS_BITS = 32;
    localparam int DAYS_W       = SECONDS_BITS - 16;

    // days = (seconds >> 7) / 675 by reciprocal multiply, exact over the input range
    localparam int DAY_PRESHIFT = 7;
    localparam int SECS_HI_W    = SECONDS_BITS - DAY_PRESHIFT;
    localparam int DAY_RECIP_SH = SECS_HI_W + 10;
    localparam int DAY_RECIP_W  = SECS_HI_W + 1;
    localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
        DAY_RECIP_W'(((64'd1 << DAY_RECIP_SH) + 64'd674) / 64'd675);

    // days / 7 by reciprocal multiply, only the low quotient bits are used
    localparam int WEEK_RECIP_SH = DAYS_W + 3;
    localparam int WEEK_RECIP_W  = DAYS_W + 1;
    localparam logic [WEEK_RECIP_W-1:0] WEEK_RECIP =
        WEEK_RECIP_W'(((64'd1 << WEEK_RECIP_SH) + 64'd6) / 64'd7);

    // result field widths
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int DOW_W   = 3;

    localparam logic [YEAR_W-1:0]     EPOCH_YEAR   = 12'd1970;
    localparam logic [1:0]            EPOCH_MOD4   = 2'd2;
    localparam logic [6:0]            EPOCH_MOD100 = 7'd70;
    localparam logic [8:0]            EPOCH_MOD400 = 9'd370;
    localparam logic [MONTH_W-1:0]    LAST_MONTH   = 4'd11;
    localparam logic [MONTH_W-1:0]    FEBRUARY     = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WEEKDAY,
        ST_YEAR_ONE,
        ST_YEAR_FOUR,
        ST_MONTH,
        ST_FINISH
    } escd_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic div_step;
        logic week_step;
        logic year_four;
        logic year_step;
        logic month_step;
        logic load_out;
    } escd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic year_done;
        logic next_aligned;
        logic month_done;
        logic out_free;
    } escd_status_t;

    // days in a month, month counted from zero
    function automatic logic [DOM_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DOM_W-1:0] len;
        case (m)
            4'd0:     len = 5'd31;
            FEBRUARY: len = leap ? 5'd29 : 5'd28;
            4'd2:     len = 5'd31;
            4'd3:     len = 5'd30;
            4'd4:     len = 5'd31;
            4'd5:     len = 5'd30;
            4'd6:     len = 5'd31;
            4'd7:     len = 5'd31;
            4'd8:     len = 5'd30;
            4'd9:     len = 5'd31;
            4'd10:    len = 5'd30;
            default:  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ sv/escd_if.sv @@
// valid/ready channel interfaces for seconds in and calendar date out
// depends on escd_pkg
`timescale 1ns / 1ps

interface escd_in_if import escd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SECONDS_BITS-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface escd_out_if import escd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
    logic [DOW_W-1:0]   day_of_week;

    modport source (output valid, output year, output month, output day_of_month,
                    output day_of_week, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input day_of_week, output ready);
endinterface

@@ sv/escd_ctrl.sv @@
// controller state machine: sequences divide, weekday, year walk and month walk
// depends on escd_pkg
`timescale 1ns / 1ps

module escd_ctrl import escd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  escd_status_t status,
    output escd_cmd_t    cmd
);

    escd_state_t            state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_WEEKDAY;
            end
            ST_WEEKDAY:
            begin
                cmd.week_step = 1'b1;
                state_next    = ST_YEAR_ONE;
            end
            ST_YEAR_ONE:
            begin
                if (status.year_done)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                    if (status.next_aligned)
                    begin
                        state_next = ST_YEAR_FOUR;
                    end
                end
            end
            ST_YEAR_FOUR:
            begin
                cmd.year_four = 1'b1;
                if (status.year_done)
                begin
                    state_next = ST_YEAR_ONE;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH:
            begin
                if (status.month_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/escd_dp.sv @@
// datapath: reciprocal-multiply divide by 86400, weekday residue, year and month walk,
// output register; depends on escd_pkg
`timescale 1ns / 1ps

module escd_dp import escd_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  escd_cmd_t               cmd,
    output escd_status_t            status,
    input  logic [SECONDS_BITS-1:0] epoch_seconds,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [YEAR_W-1:0]       year,
    output logic [MONTH_W-1:0]      month,
    output logic [DOM_W-1:0]        day_of_month,
    output logic [DOW_W-1:0]        day_of_week
);

    logic [SECONDS_BITS-1:0] secs_reg, secs_next;
    logic [DAYS_W-1:0]       days_reg, days_next;
    logic [2:0]              wmod_reg, wmod_next;
    logic [YEAR_W-1:0]       year_reg, year_next;
    logic [1:0]              m4_reg, m4_next;
    logic [6:0]              m100_reg, m100_next;
    logic [8:0]              m400_reg, m400_next;
    logic [MONTH_W-1:0]      month_reg, month_next;

    logic                    out_valid_reg;
    logic [YEAR_W-1:0]       year_out_reg;
    logic [MONTH_W-1:0]      month_out_reg;
    logic [DOM_W-1:0]        dom_out_reg;
    logic [DOW_W-1:0]        dow_out_reg;

    logic [SECS_HI_W+DAY_RECIP_W-1:0] day_prod;
    logic [DAYS_W+WEEK_RECIP_W-1:0]   week_prod;
    logic [2:0]              week_quo;
    logic                    leap;
    logic [10:0]             year_len;
    logic [DAYS_W-1:0]       year_len_ext, mlen_ext;
    logic [2:0]              year_inc;
    logic [7:0]              m100_sum;
    logic [9:0]              m400_sum;
    logic [DOM_W-1:0]        mlen;
    logic [3:0]              dow_sum, dow_wrap;
    logic [DOW_W-1:0]        dow_val;

    // whole days by reciprocal multiply, low bits of days / 7 for the weekday
    always_comb
    begin
        day_prod  = {{DAY_RECIP_W{1'b0}}, secs_reg[SECONDS_BITS-1:DAY_PRESHIFT]}
                  * {{SECS_HI_W{1'b0}}, DAY_RECIP};
        week_prod = {{WEEK_RECIP_W{1'b0}}, days_reg} * {{DAYS_W{1'b0}}, WEEK_RECIP};
        week_quo  = week_prod[WEEK_RECIP_SH +: 3];
    end

    // leap year from the year residues, year and month lengths
    always_comb
    begin
        leap         = (m4_reg == 2'd0) && ((m100_reg != 7'd0) || (m400_reg == 9'd0));
        year_len     = cmd.year_four ? (11'd1460 + {10'd0, leap}) : (11'd365 + {10'd0, leap});
        year_len_ext = {{(DAYS_W-11){1'b0}}, year_len};
        year_inc     = cmd.year_four ? 3'd4 : 3'd1;
        m100_sum     = {1'b0, m100_reg} + {5'd0, year_inc};
        m400_sum     = {1'b0, m400_reg} + {7'd0, year_inc};
        mlen         = month_length(month_reg, leap);
        mlen_ext     = {{(DAYS_W-DOM_W){1'b0}}, mlen};
    end

    // status to the controller
    always_comb
    begin
        status.year_done    = (days_reg < year_len_ext);
        status.next_aligned = (m4_reg == 2'd3);
        status.month_done   = (month_reg == LAST_MONTH) || (days_reg < mlen_ext);
        status.out_free     = !out_valid_reg || out_ready;
    end

    // working register updates
    always_comb
    begin
        secs_next  = secs_reg;
        days_next  = days_reg;
        wmod_next  = wmod_reg;
        year_next  = year_reg;
        m4_next    = m4_reg;
        m100_next  = m100_reg;
        m400_next  = m400_reg;
        month_next = month_reg;
        if (cmd.load_in)
        begin
            secs_next  = epoch_seconds;
            days_next  = '0;
            wmod_next  = 3'd0;
            year_next  = EPOCH_YEAR;
            m4_next    = EPOCH_MOD4;
            m100_next  = EPOCH_MOD100;
            m400_next  = EPOCH_MOD400;
            month_next = '0;
        end
        else if (cmd.div_step)
        begin
            days_next = day_prod[DAY_RECIP_SH +: DAYS_W];
        end
        else if (cmd.week_step)
        begin
            // days mod 7 is days plus the quotient, modulo 8
            wmod_next = days_reg[2:0] + week_quo;
        end
        else if (cmd.year_step)
        begin
            days_next = days_reg - year_len_ext;
            year_next = year_reg + {{(YEAR_W-3){1'b0}}, year_inc};
            m4_next   = m4_reg + year_inc[1:0];
            m100_next = (m100_sum >= 8'd100) ? 7'(m100_sum - 8'd100) : m100_sum[6:0];
            m400_next = (m400_sum >= 10'd400) ? 9'(m400_sum - 10'd400) : m400_sum[8:0];
        end
        else if (cmd.month_step)
        begin
            days_next  = days_reg - mlen_ext;
            month_next = month_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_reg  <= secs_next;
        days_reg  <= days_next;
        wmod_reg  <= wmod_next;
        year_reg  <= year_next;
        m4_reg    <= m4_next;
        m100_reg  <= m100_next;
        m400_reg  <= m400_next;
        month_reg <= month_next;
    end

    // weekday: epoch day is thursday, monday is one
    always_comb
    begin
        dow_sum  = {1'b0, wmod_reg} + 4'd3;
        dow_wrap = (dow_sum >= 4'd7) ? (dow_sum - 4'd7) : dow_sum;
        dow_val  = dow_wrap[2:0] + 3'd1;
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            year_out_reg  <= year_reg;
            month_out_reg <= month_reg + 1'b1;
            dom_out_reg   <= days_reg[DOM_W-1:0] + 1'b1;
            dow_out_reg   <= dow_val;
        end
    end

    assign out_valid    = out_valid_reg;
    assign year         = year_out_reg;
    assign month        = month_out_reg;
    assign day_of_month = dom_out_reg;
    assign day_of_week  = dow_out_reg;

endmodule

@@ sv/epoch_seconds_to_calendar_date_unit.sv @@
// Converts unsigned seconds since 1970-01-01 00:00:00 into Gregorian year, month, day of
// month and ISO weekday. One item is worked on at a time. After a seconds transfer the unit
// does the divide by 86400 (a reciprocal multiply), then the weekday residue, then the year
// walk (single years up to a multiple of four, four years per step, then single years
// again), then the month walk, and last loads the output register; it is then ready for
// the next seconds value. A finished date waits in an output register, so the next seconds
// value is taken while the previous date is still waiting; a new date is held back until
// that one is transferred.
// top level; depends on escd_pkg, escd_if, escd_ctrl, escd_dp and the assertion macros
`timescale 1ns / 1ps

`include "epoch_seconds_to_calendar_date_unit_defines.svh"

module epoch_seconds_to_calendar_date_unit import escd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    escd_in_if.sink     seconds,
    escd_out_if.source  date
);

    escd_cmd_t    cmd;
    escd_status_t status;

    // sequencer
    escd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (seconds.valid),
        .in_ready (seconds.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and output register
    escd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .epoch_seconds (seconds.epoch_seconds),
        .out_ready     (date.ready),
        .out_valid     (date.valid),
        .year          (date.year),
        .month         (date.month),
        .day_of_month  (date.day_of_month),
        .day_of_week   (date.day_of_week)
    );

    // checks
    `ESCD_ASSERT_NEXT(a_busy_after_transfer, seconds.valid && seconds.ready, !seconds.ready, "input taken while busy")
    `ESCD_ASSERT_NEXT(a_load_shows_result, cmd.load_out, date.valid, "loaded result not presented")
    `ESCD_ASSERT_NOW(a_result_ranges, date.valid, (date.month >= 4'd1) && (date.month <= 4'd12) && (date.day_of_month >= 5'd1) && (date.day_of_week >= 3'd1) && (date.day_of_week <= 3'd7), "result field out of range")

endmodule
